// ===== design/assert_macros.svh =====
// assertion macros used by the top level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== design/cuv_pkg.sv =====
// package for the cuboid union volume block: widths, defaults, state codes
// no dependencies
package cuv_pkg;

    localparam int MAX_CUBOIDS_DEF = 4096;
    localparam int COORD_BITS_DEF  = 18;
    localparam int CLIP_BITS       = 17;
    localparam int VOL_BITS        = 64;
    localparam int USED_BITS       = 13;
    localparam logic [CLIP_BITS-1:0] CLIP_BOUND_RESET = 17'd50;

    localparam logic [0:0] REG_CLIP_ENABLE = 1'b0;
    localparam logic [0:0] REG_CLIP_BOUND  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_OVL,
        ST_MUL,
        ST_PROD,
        ST_ACC,
        ST_REPORT
    } cuv_state_t;

endpackage

// ===== design/cuv_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module cuv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/cuboid_union_volume.sv =====
// top level of the cuboid union volume block
// depends on cuv_pkg, cuv_ram and assert_macros.svh
//
// usage: drive the command fields with start high while busy is low; the
// command is taken at that clock edge and busy rises in the next cycle.
// the block walks every entry held in the store: an entry that misses the
// command passes through memory read and overlap bounds, one that overlaps it
// also through two products and accumulate and append; an adding command then
// takes the products and accumulate and append for itself. a clipped or empty
// command reports in the first cycle after it is taken. the result appears
// for one cycle with done high, together with union_volume, entries_used and
// store_overflow; the receiver cannot stall it. busy falls in the cycle after
// done.
// configuration: cfg_we, cfg_index and cfg_data write clip_enable (index 0)
// or clip_bound (index 1) at once; write only while busy is low.
// reset clears the entry count, running volume, overflow flag and the
// registers (clip off, bound 50). the store itself needs no clearing pass:
// only entries below the count are read.
`include "assert_macros.svh"
module cuboid_union_volume #(
    parameter int MAX_CUBOIDS = cuv_pkg::MAX_CUBOIDS_DEF,
    parameter int COORD_BITS  = cuv_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [cuv_pkg::CLIP_BITS-1:0]     cfg_data,
    input  logic                              action,
    input  logic signed [COORD_BITS-1:0]      x_low,
    input  logic signed [COORD_BITS-1:0]      x_high,
    input  logic signed [COORD_BITS-1:0]      y_low,
    input  logic signed [COORD_BITS-1:0]      y_high,
    input  logic signed [COORD_BITS-1:0]      z_low,
    input  logic signed [COORD_BITS-1:0]      z_high,
    output logic [cuv_pkg::VOL_BITS-2:0]      union_volume,
    output logic [cuv_pkg::USED_BITS-1:0]     entries_used,
    output logic                              store_overflow
);
    import cuv_pkg::*;

    localparam int AW = $clog2(MAX_CUBOIDS);
    localparam int CW = AW + 1;
    localparam int DW = COORD_BITS + 1;
    localparam int BW = 2 * COORD_BITS;
    localparam int PW = 2 * DW;
    localparam int EW = 3 * BW + 1;

    typedef logic signed [COORD_BITS-1:0] crd_t;

    cuv_state_t state_reg, state_next;

    logic                 clip_en_reg;
    logic [CLIP_BITS-1:0] clip_bound_reg;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        held_reg, held_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [VOL_BITS-1:0]  sum_reg, sum_next;
    logic                 ovf_reg, ovf_next;
    logic                 on_reg;
    crd_t                 lo_reg [3];
    crd_t                 hi_reg [3];
    crd_t                 olo_reg [3];
    crd_t                 ohi_reg [3];
    logic                 osign_reg;
    logic [PW-1:0]        pxy_reg;
    logic [DW-1:0]        dz_reg;
    logic [VOL_BITS-1:0]  vol_reg;
    logic                 self_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;

    cuv_ram #(.WIDTH(EW), .DEPTH(MAX_CUBOIDS)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // clip and empty checks on the incoming command
    logic signed [COORD_BITS+1:0] lim_pos, lim_neg;
    logic in_clip, cmd_empty;
    crd_t cin_lo [3];
    crd_t cin_hi [3];

    always_comb
    begin
        cin_lo[0] = x_low;  cin_hi[0] = x_high;
        cin_lo[1] = y_low;  cin_hi[1] = y_high;
        cin_lo[2] = z_low;  cin_hi[2] = z_high;
        lim_pos = $signed({1'b0, clip_bound_reg});
        lim_neg = -lim_pos;
        in_clip = 1'b1;
        cmd_empty = 1'b0;
        for (int d = 0; d < 3; d++)
        begin
            if ((COORD_BITS+2)'(cin_lo[d]) > lim_pos || (COORD_BITS+2)'(cin_lo[d]) < lim_neg
                || (COORD_BITS+2)'(cin_hi[d]) > lim_pos
                || (COORD_BITS+2)'(cin_hi[d]) < lim_neg)
            begin
                in_clip = 1'b0;
            end
            if (cin_lo[d] > cin_hi[d])
            begin
                cmd_empty = 1'b1;
            end
        end
    end

    // overlap of the read entry and the command
    crd_t elo [3];
    crd_t ehi [3];
    crd_t ovlo [3];
    crd_t ovhi [3];
    logic ov_empty;

    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            elo[d] = rdata[EW-1-d*BW -: COORD_BITS];
            ehi[d] = rdata[EW-1-d*BW-COORD_BITS -: COORD_BITS];
        end
        ov_empty = 1'b0;
        for (int d = 0; d < 3; d++)
        begin
            ovlo[d] = (elo[d] > lo_reg[d]) ? elo[d] : lo_reg[d];
            ovhi[d] = (ehi[d] < hi_reg[d]) ? ehi[d] : hi_reg[d];
            if (ovlo[d] > ovhi[d])
            begin
                ov_empty = 1'b1;
            end
        end
    end

    // extents of the box held in olo/ohi
    logic [DW-1:0] dx, dy, dz;
    always_comb
    begin
        dx = DW'(ohi_reg[0]) - DW'(olo_reg[0]) + DW'(1);
        dy = DW'(ohi_reg[1]) - DW'(olo_reg[1]) + DW'(1);
        dz = DW'(ohi_reg[2]) - DW'(olo_reg[2]) + DW'(1);
    end

    logic          full;
    logic [EW-1:0] box_word;
    always_comb
    begin
        full = (count_reg >= CW'(MAX_CUBOIDS));
        box_word = {olo_reg[0], ohi_reg[0], olo_reg[1], ohi_reg[1],
                    olo_reg[2], ohi_reg[2], osign_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        held_next  = held_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        ovf_next   = ovf_reg;
        we    = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = box_word;
        raddr = idx_reg[AW-1:0];
        done  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    idx_next  = '0;
                    held_next = count_reg;
                    if ((clip_en_reg && !in_clip) || cmd_empty)
                    begin
                        state_next = ST_REPORT;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // ram read of idx issued here, or command itself when past the end
                if (idx_reg < held_reg)
                begin
                    state_next = ST_OVL;
                end
                else if (on_reg)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_OVL:
            begin
                idx_next = idx_reg + CW'(1);
                if (ov_empty)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_PROD;
            end
            ST_PROD:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (osign_reg)
                begin
                    sum_next = sum_reg + vol_reg;
                end
                else
                begin
                    sum_next = sum_reg - vol_reg;
                end
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    we = 1'b1;
                    count_next = count_reg + CW'(1);
                end
                state_next = self_reg ? ST_REPORT : ST_READ;
            end
            ST_REPORT:
            begin
                done = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            clip_en_reg    <= 1'b0;
            clip_bound_reg <= CLIP_BOUND_RESET;
            count_reg      <= '0;
            held_reg       <= '0;
            idx_reg        <= '0;
            sum_reg        <= '0;
            ovf_reg        <= 1'b0;
            self_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
            ovf_reg   <= ovf_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CLIP_ENABLE: clip_en_reg    <= cfg_data[0];
                    REG_CLIP_BOUND:  clip_bound_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_IDLE)
            begin
                self_reg <= 1'b0;
            end
            else if (state_reg == ST_READ && idx_reg >= held_reg)
            begin
                self_reg <= 1'b1;
            end
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            on_reg <= action;
            for (int d = 0; d < 3; d++)
            begin
                lo_reg[d] <= cin_lo[d];
                hi_reg[d] <= cin_hi[d];
            end
        end
        if (state_reg == ST_READ && idx_reg >= held_reg)
        begin
            // stored sign convention: 1 positive; osign 1 means add
            osign_reg <= 1'b1;
            for (int d = 0; d < 3; d++)
            begin
                olo_reg[d] <= lo_reg[d];
                ohi_reg[d] <= hi_reg[d];
            end
        end
        if (state_reg == ST_OVL)
        begin
            osign_reg <= ~rdata[0];
            for (int d = 0; d < 3; d++)
            begin
                olo_reg[d] <= ovlo[d];
                ohi_reg[d] <= ovhi[d];
            end
        end
        pxy_reg    <= dx * dy;
        dz_reg     <= dz;
        if (state_reg == ST_PROD)
        begin
            vol_reg <= VOL_BITS'(pxy_reg) * VOL_BITS'(dz_reg);
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    assign union_volume   = sum_reg[VOL_BITS-1] ? '0 : sum_reg[VOL_BITS-2:0];
    assign entries_used   = USED_BITS'(count_reg);
    assign store_overflow = ovf_reg;

    `ASSERT_IMPL(a_count_le_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_CUBOIDS))
    `ASSERT_NEXT(a_done_then_idle, clk, rst_n, done, state_reg == ST_IDLE)
    `ASSERT_NEXT(a_ovf_sticky, clk, rst_n, ovf_reg, ovf_reg)
    `ASSERT_IMPL(a_write_below_max, clk, rst_n, we, !full)

endmodule
